// ===== hdl/rsw_pkg.sv =====
// shared types, constants and the arctangent table for the scan-to-point pipeline
package rsw_pkg;

  localparam int unsigned MAX_SAMPLES = 4096;
  localparam int ADDR_W = 5;
  localparam int ATAN_LEN = 30;
  localparam logic signed [31:0] CORDIC_START = 32'sd652032874;

  typedef enum logic [2:0] {
    REG_POSE_X       = 3'd0,
    REG_POSE_Y       = 3'd1,
    REG_POSE_HEADING = 3'd2,
    REG_ANGLE_START  = 3'd3,
    REG_ANGLE_STEP   = 3'd4,
    REG_RANGE_LOW    = 3'd5,
    REG_RANGE_HIGH   = 3'd6,
    REG_INPUTS_READY = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [31:0]        heading;
    logic [31:0]        angle_start;
    logic [31:0]        angle_step;
    logic [31:0]        range_low;
    logic [31:0]        range_high;
    logic               inputs_ready;
  } cfg_t;

  // what travels with each sample through the pipeline
  typedef struct packed {
    logic        ok;
    logic        last;
    logic        flip;
    logic [31:0] range;
  } beam_t;

  function automatic logic [31:0] atan_bam(input int i);
    logic [31:0] r;
    case (i)
      0:       r = 32'd536870912;
      1:       r = 32'd316933406;
      2:       r = 32'd167458907;
      3:       r = 32'd85004756;
      4:       r = 32'd42667331;
      5:       r = 32'd21354465;
      6:       r = 32'd10679838;
      7:       r = 32'd5340245;
      8:       r = 32'd2670163;
      9:       r = 32'd1335087;
      10:      r = 32'd667544;
      11:      r = 32'd333772;
      12:      r = 32'd166886;
      13:      r = 32'd83443;
      14:      r = 32'd41722;
      15:      r = 32'd20861;
      16:      r = 32'd10430;
      17:      r = 32'd5215;
      18:      r = 32'd2608;
      19:      r = 32'd1304;
      20:      r = 32'd652;
      21:      r = 32'd326;
      22:      r = 32'd163;
      23:      r = 32'd81;
      24:      r = 32'd41;
      25:      r = 32'd20;
      26:      r = 32'd10;
      27:      r = 32'd5;
      28:      r = 32'd3;
      29:      r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/rsw_front.sv =====
// sample qualification and beam angle setup ahead of the cordic chain
module rsw_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                take,
  input  logic [31:0]         range_sample,
  input  logic                range_finite,
  input  logic [11:0]         sample_index,
  input  logic                scan_last,
  input  rsw_pkg::cfg_t       cfg,
  output logic                o_valid,
  output rsw_pkg::beam_t      o_beam,
  output logic signed [32:0]  o_z
);

  logic                  v1_r, v1_nxt;
  rsw_pkg::beam_t        beam1_r, beam1_nxt;
  logic [31:0]           prod1_r, prod1_nxt;
  logic                  v2_r;
  rsw_pkg::beam_t        beam2_r, beam2_nxt;
  logic signed [32:0]    z2_r, z2_nxt;
  logic [31:0]           angle;
  logic [31:0]           red;

  always_comb begin
    v1_nxt          = take;
    beam1_nxt.ok    = cfg.inputs_ready && range_finite &&
                      (range_sample >= cfg.range_low) &&
                      (range_sample <= cfg.range_high) &&
                      (32'(sample_index) < 32'(rsw_pkg::MAX_SAMPLES));
    beam1_nxt.last  = scan_last;
    beam1_nxt.flip  = 1'b0;
    beam1_nxt.range = range_sample;
    prod1_nxt       = 32'(32'(sample_index) * cfg.angle_step);
  end

  // quadrants 01 and 10 are turned by half a turn and negated at the end
  always_comb begin
    angle          = cfg.angle_start + prod1_r + cfg.heading;
    beam2_nxt      = beam1_r;
    beam2_nxt.flip = angle[31] ^ angle[30];
    red            = {angle[31] ^ beam2_nxt.flip, angle[30:0]};
    z2_nxt         = $signed({red[31], red});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v1_nxt;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      beam1_r <= beam1_nxt;
      prod1_r <= prod1_nxt;
      beam2_r <= beam2_nxt;
      z2_r    <= z2_nxt;
    end
  end

  assign o_valid = v2_r;
  assign o_beam  = beam2_r;
  assign o_z     = z2_r;

endmodule

// ===== hdl/rsw_cordic_cell.sv =====
// one rotation step of the cordic chain with its pipeline register
module rsw_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               i_valid,
  input  rsw_pkg::beam_t     i_beam,
  input  logic signed [31:0] i_x,
  input  logic signed [31:0] i_y,
  input  logic signed [32:0] i_z,
  output logic               o_valid,
  output rsw_pkg::beam_t     o_beam,
  output logic signed [31:0] o_x,
  output logic signed [31:0] o_y,
  output logic signed [32:0] o_z
);

  logic                  valid_r;
  rsw_pkg::beam_t        beam_r;
  logic signed [31:0]    x_r, x_nxt;
  logic signed [31:0]    y_r, y_nxt;
  logic signed [32:0]    z_r, z_nxt;
  logic signed [31:0]    dx;
  logic signed [31:0]    dy;
  logic signed [32:0]    at;

  always_comb begin
    dx = i_y >>> STAGE;
    dy = i_x >>> STAGE;
    at = $signed({1'b0, rsw_pkg::atan_bam(STAGE)});
    if (!i_z[32]) begin
      x_nxt = i_x - dx;
      y_nxt = i_y + dy;
      z_nxt = i_z - at;
    end else begin
      x_nxt = i_x + dx;
      y_nxt = i_y - dy;
      z_nxt = i_z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      beam_r <= i_beam;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_beam  = beam_r;
  assign o_x     = x_r;
  assign o_y     = y_r;
  assign o_z     = z_r;

endmodule

// ===== hdl/rsw_back.sv =====
// quadrant fix, range scaling, rounding and pose offset with saturation
module rsw_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               i_valid,
  input  rsw_pkg::beam_t     i_beam,
  input  logic signed [31:0] i_x,
  input  logic signed [31:0] i_y,
  input  logic signed [31:0] pose_x,
  input  logic signed [31:0] pose_y,
  output logic               o_valid,
  output logic               o_ok,
  output logic               o_last,
  output logic signed [31:0] o_point_x,
  output logic signed [31:0] o_point_y
);

  localparam logic signed [64:0] HALF = 65'sd536870912;
  localparam logic signed [35:0] SAT_HI = 36'sd2147483647;
  localparam logic signed [35:0] SAT_LO = -36'sd2147483648;

  logic                  vn_r, vm_r, vr_r;
  rsw_pkg::beam_t        bn_r, bm_r, br_r;
  logic signed [31:0]    xn_r, yn_r;
  logic signed [64:0]    px_r, py_r, px_nxt, py_nxt;
  logic signed [64:0]    qx, qy;
  logic signed [34:0]    rx_r, ry_r;
  logic signed [35:0]    sx, sy;

  always_comb begin
    px_nxt = $signed({1'b0, bn_r.range}) * xn_r;
    py_nxt = $signed({1'b0, bn_r.range}) * yn_r;
    // round half up, then floor shift to q16.16
    qx     = px_r + HALF;
    qy     = py_r + HALF;
  end

  always_comb begin
    sx = 36'(rx_r) + 36'(pose_x);
    sy = 36'(ry_r) + 36'(pose_y);
    if (!br_r.ok) begin
      o_point_x = '0;
    end else if (sx > SAT_HI) begin
      o_point_x = SAT_HI[31:0];
    end else if (sx < SAT_LO) begin
      o_point_x = SAT_LO[31:0];
    end else begin
      o_point_x = sx[31:0];
    end
    if (!br_r.ok) begin
      o_point_y = '0;
    end else if (sy > SAT_HI) begin
      o_point_y = SAT_HI[31:0];
    end else if (sy < SAT_LO) begin
      o_point_y = SAT_LO[31:0];
    end else begin
      o_point_y = sy[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vn_r <= 1'b0;
      vm_r <= 1'b0;
      vr_r <= 1'b0;
    end else if (adv) begin
      vn_r <= i_valid;
      vm_r <= vn_r;
      vr_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bn_r <= i_beam;
      xn_r <= i_beam.flip ? -i_x : i_x;
      yn_r <= i_beam.flip ? -i_y : i_y;
      bm_r <= bn_r;
      px_r <= px_nxt;
      py_r <= py_nxt;
      br_r <= bm_r;
      rx_r <= qx[64:30];
      ry_r <= qy[64:30];
    end
  end

  assign o_valid = vr_r;
  assign o_ok    = br_r.ok;
  assign o_last  = br_r.last;

endmodule

// ===== hdl/range_scan_to_world_points.sv =====
// top level: config registers, front end, cordic cell chain, back end, output register
//
//  channel | direction | transfer when            | payload
//  in_     | input     | in_valid && !in_stall    | range_sample, range_finite, sample_index,
//          |           |                          | scan_last
//  out_    | output    | out_valid && !out_stall  | point_x, point_y, point_valid, point_last
//  cfg     | apb write | psel & penable & pwrite  | pwdata to register paddr[4:2]
//
// one sample per cycle while in_stall is low; the pipeline is the cordic cell chain
// (one cell per stage) plus two front, three back and one output register stage.
// reset (rst_n low, synchronous) clears the config and valid registers to 0 and empties the pipeline.
// a stalled result holds in the output register; the pipeline keeps moving while its
// last stage is empty, and in_stall rises only when a result waits behind a stalled one.
module range_scan_to_world_points #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [31:0]                  in_range_sample,
  input  logic                         in_range_finite,
  input  logic [11:0]                  in_sample_index,
  input  logic                         in_scan_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [31:0]           out_point_x,
  output logic signed [31:0]           out_point_y,
  output logic                         out_point_valid,
  output logic                         out_point_last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rsw_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  rsw_pkg::cfg_t       cfg_r, cfg_nxt;
  rsw_pkg::reg_idx_t   widx;
  logic                wr_en;

  logic                adv;
  logic                load_out;
  logic                take;

  logic                cv [CORDIC_STAGES+1];
  rsw_pkg::beam_t      cb [CORDIC_STAGES+1];
  logic signed [31:0]  cx [CORDIC_STAGES+1];
  logic signed [31:0]  cy [CORDIC_STAGES+1];
  logic signed [32:0]  cz [CORDIC_STAGES+1];

  logic                bk_valid;
  logic                bk_ok;
  logic                bk_last;
  logic signed [31:0]  bk_x;
  logic signed [31:0]  bk_y;

  logic                out_valid_r;
  logic signed [31:0]  out_x_r;
  logic signed [31:0]  out_y_r;
  logic                out_ok_r;
  logic                out_last_r;

  // configuration port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = rsw_pkg::reg_idx_t'(paddr[4:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (widx)
        rsw_pkg::REG_POSE_X:       cfg_nxt.pose_x       = pwdata;
        rsw_pkg::REG_POSE_Y:       cfg_nxt.pose_y       = pwdata;
        rsw_pkg::REG_POSE_HEADING: cfg_nxt.heading      = pwdata;
        rsw_pkg::REG_ANGLE_START:  cfg_nxt.angle_start  = pwdata;
        rsw_pkg::REG_ANGLE_STEP:   cfg_nxt.angle_step   = pwdata;
        rsw_pkg::REG_RANGE_LOW:    cfg_nxt.range_low    = pwdata;
        rsw_pkg::REG_RANGE_HIGH:   cfg_nxt.range_high   = pwdata;
        rsw_pkg::REG_INPUTS_READY: cfg_nxt.inputs_ready = pwdata[0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (widx)
      rsw_pkg::REG_POSE_X:       prdata = cfg_r.pose_x;
      rsw_pkg::REG_POSE_Y:       prdata = cfg_r.pose_y;
      rsw_pkg::REG_POSE_HEADING: prdata = cfg_r.heading;
      rsw_pkg::REG_ANGLE_START:  prdata = cfg_r.angle_start;
      rsw_pkg::REG_ANGLE_STEP:   prdata = cfg_r.angle_step;
      rsw_pkg::REG_RANGE_LOW:    prdata = cfg_r.range_low;
      rsw_pkg::REG_RANGE_HIGH:   prdata = cfg_r.range_high;
      rsw_pkg::REG_INPUTS_READY: prdata = {31'd0, cfg_r.inputs_ready};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // flow control: the whole chain shifts unless a result waits behind a stalled one
  assign load_out = !out_valid_r || !out_stall;
  assign adv      = load_out || !bk_valid;
  assign in_stall = !adv;
  assign take     = in_valid && adv;

  rsw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .take         (take),
    .range_sample (in_range_sample),
    .range_finite (in_range_finite),
    .sample_index (in_sample_index),
    .scan_last    (in_scan_last),
    .cfg          (cfg_r),
    .o_valid      (cv[0]),
    .o_beam       (cb[0]),
    .o_z          (cz[0])
  );

  assign cx[0] = rsw_pkg::CORDIC_START;
  assign cy[0] = '0;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    rsw_cordic_cell #(
      .STAGE (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .i_valid (cv[g]),
      .i_beam  (cb[g]),
      .i_x     (cx[g]),
      .i_y     (cy[g]),
      .i_z     (cz[g]),
      .o_valid (cv[g+1]),
      .o_beam  (cb[g+1]),
      .o_x     (cx[g+1]),
      .o_y     (cy[g+1]),
      .o_z     (cz[g+1])
    );
  end

  rsw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .i_valid   (cv[CORDIC_STAGES]),
    .i_beam    (cb[CORDIC_STAGES]),
    .i_x       (cx[CORDIC_STAGES]),
    .i_y       (cy[CORDIC_STAGES]),
    .pose_x    (cfg_r.pose_x),
    .pose_y    (cfg_r.pose_y),
    .o_valid   (bk_valid),
    .o_ok      (bk_ok),
    .o_last    (bk_last),
    .o_point_x (bk_x),
    .o_point_y (bk_y)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= bk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x_r    <= bk_x;
      out_y_r    <= bk_y;
      out_ok_r   <= bk_ok;
      out_last_r <= bk_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_x     = out_x_r;
  assign out_point_y     = out_y_r;
  assign out_point_valid = out_ok_r;
  assign out_point_last  = out_last_r;

endmodule

// ===== tb/range_scan_to_world_points_test.sv =====
// self-checking testbench for range_scan_to_world_points: directed and random scans vs a predictor
module range_scan_to_world_points_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CORDIC_N = 16;
  localparam int LATENCY = CORDIC_N + 6;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 190;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               valid;
    logic               last;
  } world_point_t;

  class point_scoreboard;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [31:0]        heading;
    logic [31:0]        beam_start;
    logic [31:0]        beam_step;
    logic [31:0]        range_lo;
    logic [31:0]        range_hi;
    logic               ready;
    longint             atan_tab[CORDIC_N];
    world_point_t       pending_points[$];
    int                 errors;

    function new();
      pose_x = '0;
      pose_y = '0;
      heading = '0;
      beam_start = '0;
      beam_step = '0;
      range_lo = '0;
      range_hi = '0;
      ready = 1'b0;
      errors = 0;
      atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                   10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                   83443, 41722, 20861};
    endfunction

    function void set_reg(rsw_pkg::reg_idx_t r, logic [31:0] v);
      case (r)
        rsw_pkg::REG_POSE_X:       pose_x = v;
        rsw_pkg::REG_POSE_Y:       pose_y = v;
        rsw_pkg::REG_POSE_HEADING: heading = v;
        rsw_pkg::REG_ANGLE_START:  beam_start = v;
        rsw_pkg::REG_ANGLE_STEP:   beam_step = v;
        rsw_pkg::REG_RANGE_LOW:    range_lo = v;
        rsw_pkg::REG_RANGE_HIGH:   range_hi = v;
        rsw_pkg::REG_INPUTS_READY: ready = v[0];
        default: ;
      endcase
    endfunction

    // rotation-mode cordic on a binary angle, q2.30 cos and sin
    function void rotate_beam(input logic [31:0] ang, output longint c, output longint s);
      logic        flip;
      logic [31:0] a;
      longint      z, x, y, dx, dy;
      // second and third quadrants are folded by half a turn
      flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
      a = flip ? ang - 32'h8000_0000 : ang;
      z = longint'(signed'(a));
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_N; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - atan_tab[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + atan_tab[i];
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c = x;
      s = y;
    endfunction

    function logic signed [31:0] project(logic [31:0] range_q, longint trig,
                                         logic signed [31:0] pose);
      longint p;
      p = longint'({32'b0, range_q}) * trig + (longint'(1) <<< 29);
      p = (p >>> 30) + longint'(pose);
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return p[31:0];
    endfunction

    function void note_sample(logic [31:0] range_q, logic finite, logic [11:0] idx,
                              logic last);
      world_point_t pt;
      logic [31:0]  ang;
      longint       c, s;
      pt.x = '0;
      pt.y = '0;
      pt.last = last;
      pt.valid = ready && finite && range_q >= range_lo && range_q <= range_hi &&
                 32'(idx) < rsw_pkg::MAX_SAMPLES;
      if (pt.valid) begin
        ang = beam_start + 32'(idx) * beam_step + heading;
        rotate_beam(ang, c, s);
        pt.x = project(range_q, c, pose_x);
        pt.y = project(range_q, s, pose_y);
      end
      pending_points.push_back(pt);
    endfunction

    function void check_point(logic signed [31:0] x, logic signed [31:0] y, logic valid,
                              logic last);
      world_point_t e;
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected point, expected none, got x=%0d y=%0d valid=%b last=%b",
                 $time, x, y, valid, last);
        return;
      end
      e = pending_points.pop_front();
      if (x !== e.x) begin
        errors++;
        $display("%0t: point_x expected %0d got %0d", $time, e.x, x);
      end
      if (y !== e.y) begin
        errors++;
        $display("%0t: point_y expected %0d got %0d", $time, e.y, y);
      end
      if (valid !== e.valid) begin
        errors++;
        $display("%0t: point_valid expected %b got %b", $time, e.valid, valid);
      end
      if (last !== e.last) begin
        errors++;
        $display("%0t: point_last expected %b got %b", $time, e.last, last);
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [31:0]                in_range_sample = '0;
  logic                       in_range_finite = 1'b0;
  logic [11:0]                in_sample_index = '0;
  logic                       in_scan_last = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [31:0]         out_point_x;
  logic signed [31:0]         out_point_y;
  logic                       out_point_valid;
  logic                       out_point_last;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [rsw_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  point_scoreboard sb;
  logic            calm = 1'b0;
  int              quiet_cycles = 0;

  range_scan_to_world_points #(.CORDIC_STAGES(CORDIC_N)) dut (.*);

  always #10 clk = ~clk;

  // result side: check each transfer, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_point(out_point_x, out_point_y, out_point_valid, out_point_last);
    end
    out_stall <= !calm && ($urandom_range(0, 99) < 28);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_write(rsw_pkg::reg_idx_t r, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(r, v);
    @(posedge clk);
  endtask

  // waits for the pipeline to empty, then writes every register
  task automatic program_setup(logic [31:0] px, logic [31:0] py, logic [31:0] hd,
                               logic [31:0] a0, logic [31:0] step, logic [31:0] lo,
                               logic [31:0] hi, logic rdy);
    in_valid <= 1'b0;
    while (sb.pending_points.size() != 0) @(posedge clk);
    cfg_write(rsw_pkg::REG_POSE_X, px);
    cfg_write(rsw_pkg::REG_POSE_Y, py);
    cfg_write(rsw_pkg::REG_POSE_HEADING, hd);
    cfg_write(rsw_pkg::REG_ANGLE_START, a0);
    cfg_write(rsw_pkg::REG_ANGLE_STEP, step);
    cfg_write(rsw_pkg::REG_RANGE_LOW, lo);
    cfg_write(rsw_pkg::REG_RANGE_HIGH, hi);
    cfg_write(rsw_pkg::REG_INPUTS_READY, {31'b0, rdy});
  endtask

  task automatic send_sample(logic [31:0] range_q, logic finite, logic [11:0] idx,
                             logic last);
    while (!calm && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_range_sample <= range_q;
    in_range_finite <= finite;
    in_sample_index <= idx;
    in_scan_last <= last;
    do @(posedge clk); while (in_stall);
    sb.note_sample(range_q, finite, idx, last);
  endtask

  task automatic random_sample();
    logic [31:0] r;
    int          sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3, 4, 5: r = $urandom_range(sb.range_hi, sb.range_lo);
      6:                r = $urandom;
      7:                r = sb.range_lo - 32'($urandom_range(0, 1));
      8:                r = sb.range_hi + 32'($urandom_range(0, 1));
      default:          r = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
    send_sample(r, $urandom_range(0, 15) != 0, 12'($urandom_range(0, 4095)),
                $urandom_range(0, 15) == 0);
  endtask

  task automatic random_phase(int p);
    logic [31:0] px, py, lo, hi;
    case (p)
      0: program_setup(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                       32'h0, 32'hFFFF_FFFF, 1'b1);
      // only the largest range passes the window
      1: program_setup(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      default: begin
        px = $urandom;
        py = $urandom;
        if ($urandom_range(0, 1) == 1) px = {{8{px[23]}}, px[23:0]};
        if ($urandom_range(0, 1) == 1) py = {{8{py[23]}}, py[23:0]};
        lo = $urandom_range(0, 32'h0010_0000);
        hi = lo + $urandom_range(0, 32'h0400_0000);
        program_setup(px, py, $urandom, $urandom, $urandom, lo, hi, p != 3);
      end
    endcase
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // registers still at reset: nothing is ready, every sample drops
    send_sample(32'd100, 1'b1, 12'd5, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1, 12'd4095, 1'b1);
    send_sample(32'h0, 1'b0, 12'd0, 1'b0);

    // one beam per 1/4096 turn, open window
    program_setup(32'h0, 32'h0, 32'h0, 32'h0, 32'h0010_0000, 32'h0, 32'hFFFF_FFFF, 1'b1);
    send_sample(32'h0, 1'b1, 12'd0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1, 12'd0, 1'b0);
    send_sample(32'h0001_0000, 1'b1, 12'd512, 1'b0);
    send_sample(32'h0001_0000, 1'b1, 12'd1024, 1'b0);
    send_sample(32'h0001_0000, 1'b1, 12'd1536, 1'b0);
    send_sample(32'h0001_0000, 1'b1, 12'd2048, 1'b0);
    send_sample(32'h0001_0000, 1'b1, 12'd2560, 1'b0);
    send_sample(32'h0001_0000, 1'b1, 12'd3072, 1'b0);
    send_sample(32'h0001_0000, 1'b1, 12'd3584, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1, 12'd2048, 1'b0);
    send_sample(32'h0001_0000, 1'b0, 12'd7, 1'b0);
    send_sample(32'h0001_0000, 1'b1, 12'd4095, 1'b1);

    // pose at the corners, window edges, saturation on both axes
    program_setup(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                  32'h0001_0000, 32'h0020_0000, 1'b1);
    send_sample(32'h0001_0000, 1'b1, 12'd0, 1'b0);
    send_sample(32'h0000_FFFF, 1'b1, 12'd1, 1'b0);
    send_sample(32'h0020_0000, 1'b1, 12'd2, 1'b0);
    send_sample(32'h0020_0001, 1'b1, 12'd3, 1'b0);
    send_sample(32'h0020_0000, 1'b1, 12'd4095, 1'b1);

    // empty window: low above high
    program_setup(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0010_0000,
                  32'h000F_FFFF, 1'b1);
    send_sample(32'h0010_0000, 1'b1, 12'd10, 1'b0);
    send_sample(32'h000F_FFFF, 1'b1, 12'd11, 1'b1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_phase(p);
      calm <= (p == 4);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_sample();
    end

    in_valid <= 1'b0;
    while (sb.pending_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rsw_pkg.sv
hdl/rsw_front.sv
hdl/rsw_cordic_cell.sv
hdl/rsw_back.sv
hdl/range_scan_to_world_points.sv
tb/range_scan_to_world_points_test.sv
